// ===== rtl/core/narls_pkg.sv =====
// Package for the no-adjacent-repeat letter scheduler.
// Beat types, controller/datapath command and status structs, shared constants.
// No dependencies.
`default_nettype none

package narls_pkg;

    localparam int LETTER_W     = 5;
    localparam int MAX_LEN_DEF  = 64;
    localparam int ALPHABET_DEF = 26;
    localparam int GROUP_SIZE   = 8;      // counters per first-stage argmax group

    localparam logic [LETTER_W-1:0] NONE_MARK = 5'd31;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                end_of_text;
    } item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] out_letter;
        logic                failed;
        logic                run_end;
    } result_t;

    typedef struct packed {
        logic load;      // count the input beat
        logic search;    // register first-stage group winners
        logic exclude;   // leave the previous letter out of the search
        logic check;     // feasibility check on the unmasked maximum
        logic pick;      // take the winner, decrement it
        logic emit;      // load the result register
        logic clear;     // return to the empty state
    } cmd_t;

    typedef struct packed {
        logic empty;       // nothing counted and no overflow
        logic infeasible;  // overflow or max count above half the length, rounded up
        logic last;        // one letter left
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/no_adjacent_repeat_letter_scheduler.sv =====
// Top level of the no-adjacent-repeat letter scheduler.
// Instantiates narls_ctrl and narls_dpath; types from narls_pkg.
//
// Letters are taken one beat per cycle while busy is low; a beat is taken when
// start is high and busy is low. Codes at or above ALPHABET are ignored. The beat
// with end_of_text set raises busy: a maximum search and a feasibility check
// follow, then each letter of the rearrangement passes through a masked search
// and a pick, the two stages of the registered argmax over the letter counters.
// An empty run ends after the search, and a failed run after the check.
// Results appear for one cycle with result_strobe and cannot be held off; a failed
// run gives a single beat with failed and run_end set. The next run may start as
// soon as busy drops, while the last result is still on the ports.
`default_nettype none

module no_adjacent_repeat_letter_scheduler #(
    parameter int MAX_LEN  = narls_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = narls_pkg::ALPHABET_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire narls_pkg::item_t   item,
    output logic                    busy,
    output logic                    result_strobe,
    output narls_pkg::result_t      result
);

    narls_pkg::cmd_t  cmd;
    narls_pkg::stat_t stat;

    narls_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .end_of_text (item.end_of_text),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy),
        .strobe      (result_strobe)
    );

    narls_dpath #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    // every result beat follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result beat without preceding work");

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.failed) |-> (result.run_end && result.out_letter == '0))
        else $error("failed beat malformed");

    // neighbors within a run differ
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.failed && $past(result_strobe, 2)
         && !$past(result.run_end, 2))
        |-> (result.out_letter != $past(result.out_letter, 2)))
        else $error("adjacent letters repeat");

endmodule

`default_nettype wire

// ===== rtl/core/narls_dpath.sv =====
// Datapath of the letter scheduler: letter counters, length, previous letter,
// two-stage registered argmax and the result register. Uses narls_pkg.
`default_nettype none

module narls_dpath #(
    parameter int MAX_LEN  = narls_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = narls_pkg::ALPHABET_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire narls_pkg::item_t  item,
    input  wire narls_pkg::cmd_t   cmd,
    output narls_pkg::stat_t       stat,
    output narls_pkg::result_t     result
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int NGROUP = (ALPHABET + narls_pkg::GROUP_SIZE - 1) / narls_pkg::GROUP_SIZE;
    localparam int LW     = narls_pkg::LETTER_W;

    logic [LEN_W-1:0] count_reg [ALPHABET];
    logic [LEN_W-1:0] count_next [ALPHABET];
    logic [LEN_W-1:0] total_reg, total_next;
    logic [LW-1:0]    prev_reg, prev_next;
    logic             ovf_reg, ovf_next;

    logic [LEN_W-1:0] grp_c_reg [NGROUP];
    logic [LW-1:0]    grp_i_reg [NGROUP];
    logic [LEN_W-1:0] grp_c_next [NGROUP];
    logic [LW-1:0]    grp_i_next [NGROUP];

    logic [LEN_W-1:0] best_c;
    logic [LW-1:0]    best_i;
    logic [LEN_W:0]   half;
    logic             in_range;
    logic             full;

    narls_pkg::result_t result_reg, result_next;

    assign in_range = ({1'b0, item.letter} < (LW + 1)'(ALPHABET));
    assign full     = ({1'b0, total_reg} >= (LEN_W + 1)'(MAX_LEN));
    assign half     = ({1'b0, total_reg} + (LEN_W + 1)'(1)) >> 1;

    // first stage: linear argmax within each group, ties to the higher code
    always_comb
    begin
        int               idx;
        logic [LEN_W-1:0] c;
        for (int g = 0; g < NGROUP; g++)
        begin
            grp_c_next[g] = '0;
            grp_i_next[g] = LW'(g * narls_pkg::GROUP_SIZE);
            for (int j = 0; j < narls_pkg::GROUP_SIZE; j++)
            begin
                idx = g * narls_pkg::GROUP_SIZE + j;
                if (idx < ALPHABET)
                begin
                    c = count_reg[idx];
                    if (cmd.exclude && (LW'(idx) == prev_reg))
                        c = '0;
                    if (c != '0 && c >= grp_c_next[g])
                    begin
                        grp_c_next[g] = c;
                        grp_i_next[g] = LW'(idx);
                    end
                end
            end
        end
    end

    // second stage: combine group winners; later groups hold higher codes
    always_comb
    begin
        best_c = grp_c_reg[0];
        best_i = grp_i_reg[0];
        for (int g = 1; g < NGROUP; g++)
        begin
            if (grp_c_reg[g] != '0 && grp_c_reg[g] >= best_c)
            begin
                best_c = grp_c_reg[g];
                best_i = grp_i_reg[g];
            end
        end
    end

    assign stat.empty      = (total_reg == '0) && !ovf_reg;
    assign stat.infeasible = ovf_reg || ({1'b0, best_c} > half);
    assign stat.last       = (total_reg == LEN_W'(1));

    always_comb
    begin
        for (int i = 0; i < ALPHABET; i++)
        begin
            count_next[i] = count_reg[i];
            if (cmd.load && in_range && !full && item.letter == LW'(i))
                count_next[i] = count_reg[i] + LEN_W'(1);
            if (cmd.pick && best_i == LW'(i))
                count_next[i] = count_reg[i] - LEN_W'(1);
            if (cmd.clear)
                count_next[i] = '0;
        end

        total_next = total_reg;
        ovf_next   = ovf_reg;
        prev_next  = prev_reg;
        if (cmd.load && in_range)
        begin
            if (full)
                ovf_next = 1'b1;
            else
                total_next = total_reg + LEN_W'(1);
        end
        if (cmd.pick)
        begin
            total_next = total_reg - LEN_W'(1);
            prev_next  = best_i;
        end
        if (cmd.clear)
        begin
            total_next = '0;
            ovf_next   = 1'b0;
            prev_next  = narls_pkg::NONE_MARK;
        end

        result_next = result_reg;
        if (cmd.emit)
        begin
            if (cmd.check)
            begin
                result_next.out_letter = '0;
                result_next.failed     = 1'b1;
                result_next.run_end    = 1'b1;
            end
            else
            begin
                result_next.out_letter = best_i;
                result_next.failed     = 1'b0;
                result_next.run_end    = stat.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
                count_reg[i] <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            prev_reg  <= narls_pkg::NONE_MARK;
        end
        else
        begin
            for (int i = 0; i < ALPHABET; i++)
                count_reg[i] <= count_next[i];
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            for (int g = 0; g < NGROUP; g++)
            begin
                grp_c_reg[g] <= grp_c_next[g];
                grp_i_reg[g] <= grp_i_next[g];
            end
        end
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/narls_ctrl.sv =====
// Controller of the letter scheduler: sequences counting, feasibility check
// and the search/pick loop; drives busy and the result strobe. Uses narls_pkg.
`default_nettype none

module narls_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             end_of_text,
    input  wire narls_pkg::stat_t stat,
    output narls_pkg::cmd_t       cmd,
    output logic                  busy,
    output logic                  strobe
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAXF = 3'd1;   // unmasked max search
    localparam logic [2:0] ST_MAXP = 3'd2;   // feasibility check
    localparam logic [2:0] ST_FIND = 3'd3;   // masked search, first stage
    localparam logic [2:0] ST_PICK = 3'd4;   // final stage, emit one letter

    logic [2:0] state_reg, state_next;
    logic       strobe_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
                if (start && end_of_text)
                    state_next = ST_MAXF;
            end
            ST_MAXF:
            begin
                if (stat.empty)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.search = 1'b1;
                    state_next = ST_MAXP;
                end
            end
            ST_MAXP:
            begin
                cmd.check = 1'b1;
                if (stat.infeasible)
                begin
                    cmd.emit   = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_FIND;
            end
            ST_FIND:
            begin
                cmd.search  = 1'b1;
                cmd.exclude = 1'b1;
                state_next  = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick = 1'b1;
                cmd.emit = 1'b1;
                if (stat.last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_FIND;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= cmd.emit;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;

endmodule

`default_nettype wire
